>>> rtl/int4dq_pkg.sv
// ----------------------------------------------------------------------------
// int4dq_pkg: shared types and constants of the int4 tile dequantiser
// Chunk layout, configuration register indexes and the structures passed
// between the front end, the work queue and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

package int4dq_pkg;

    // Chunk layout in bytes.
    localparam logic [12:0] CHUNK_LAST  = 13'd5119;
    localparam logic [12:0] ZERO_BASE   = 13'd512;
    localparam logic [12:0] PACKED_BASE = 13'd1024;

    // Limits of the matrix geometry.
    localparam logic [6:0]  MAX_TILE_COLUMNS = 7'd64;
    localparam logic [17:0] MAX_CHUNKS       = 18'd131072;

    // Largest finite bf16 magnitude that is still accepted (100.0).
    localparam logic [14:0] BF16_LIMIT = 15'h42C8;

    // Depth of the queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GROUP_MAJOR = 2'd0,
        CFG_SIGNED      = 2'd1,
        CFG_TILE_COLS   = 2'd2,
        CFG_CHUNKS      = 2'd3
    } t_cfg_idx;

    // Configuration seen by the front end.
    typedef struct packed {
        logic        group_major;
        logic [6:0]  tile_columns;
        logic [17:0] chunk_count;
    } t_front_cfg;

    // One packed byte with everything the arithmetic needs.
    typedef struct packed {
        logic [16:0] grid_row;
        logic [3:0]  row_pair;
        logic [13:0] col;
        logic [7:0]  data;
        logic [15:0] scale0;
        logic [15:0] scale1;
        logic [15:0] zero0;
        logic [15:0] zero1;
        logic        last;
    } t_entry;

    // Tag that travels with one result through the arithmetic pipeline.
    typedef struct packed {
        logic [21:0] row;
        logic [13:0] col;
        logic        last_pair;
        logic        last_matrix;
    } t_tag;

endpackage

`default_nettype wire

>>> rtl/int4dq_front.sv
// ----------------------------------------------------------------------------
// int4dq_front: byte classifier and table store
// Tracks the position in the chunk stream, fills the scale and zero-point
// tables, and forwards each packed byte with its four table entries.
// ----------------------------------------------------------------------------
`default_nettype none

module int4dq_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  int4dq_pkg::t_front_cfg   i_cfg,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire  [7:0]               i_data_byte,
    output logic                     o_push_valid,
    input  wire                      i_push_ready,
    output int4dq_pkg::t_entry       o_push_entry
);

    logic [15:0] r_scale_mem [256];
    logic [15:0] r_zero_mem  [256];

    logic [12:0] r_byte_pos;
    logic [5:0]  r_tile_col;
    logic [16:0] r_grid_row;
    logic [16:0] r_chunk;
    logic [7:0]  r_pending;

    logic        r_f1_valid;
    logic [16:0] r_f1_grid_row;
    logic [3:0]  r_f1_row_pair;
    logic [13:0] r_f1_col;
    logic [7:0]  r_f1_data;
    logic        r_f1_last;
    logic [15:0] r_rd_scale0, r_rd_scale1, r_rd_zero0, r_rd_zero1;

    logic        accept;
    logic        push;
    logic        is_packed;
    logic [11:0] k;
    logic [7:0]  col8;
    logic [4:0]  row0;
    logic [4:0]  row1;
    logic [7:0]  idx0;
    logic [7:0]  idx1;
    logic [6:0]  cols_eff;
    logic [17:0] chunks_eff;
    logic        last_chunk;
    logic [12:0] k_full;

    assign push       = r_f1_valid & i_push_ready;
    assign o_in_ready = ~r_f1_valid | i_push_ready;
    assign accept     = i_in_valid & o_in_ready;
    assign is_packed  = r_byte_pos >= int4dq_pkg::PACKED_BASE;

    // Position of a packed byte inside the tile.
    always_comb begin
        k_full = r_byte_pos - int4dq_pkg::PACKED_BASE;
        k      = k_full[11:0];
        col8   = k[10:3];
        row0   = {k[11], k[2:0], 1'b0};
        row1   = {k[11], k[2:0], 1'b1};
        idx0   = i_cfg.group_major ? {col8[7:5], row0} : {row0, col8[7:5]};
        idx1   = i_cfg.group_major ? {col8[7:5], row1} : {row1, col8[7:5]};
    end

    // Effective geometry with out-of-range values clamped.
    always_comb begin
        if (i_cfg.tile_columns == 7'd0) begin
            cols_eff = 7'd1;
        end else if (i_cfg.tile_columns > int4dq_pkg::MAX_TILE_COLUMNS) begin
            cols_eff = int4dq_pkg::MAX_TILE_COLUMNS;
        end else begin
            cols_eff = i_cfg.tile_columns;
        end
        if (i_cfg.chunk_count == 18'd0) begin
            chunks_eff = 18'd1;
        end else if (i_cfg.chunk_count > int4dq_pkg::MAX_CHUNKS) begin
            chunks_eff = int4dq_pkg::MAX_CHUNKS;
        end else begin
            chunks_eff = i_cfg.chunk_count;
        end
        last_chunk = ({1'b0, r_chunk} + 18'd1) >= chunks_eff;
    end

    // Table writes on the odd byte of each entry, and reads for packed bytes.
    always_ff @(posedge i_clk) begin
        if (accept && !is_packed && r_byte_pos[0]) begin
            if (r_byte_pos < int4dq_pkg::ZERO_BASE) begin
                r_scale_mem[r_byte_pos[8:1]] <= {i_data_byte, r_pending};
            end else begin
                r_zero_mem[r_byte_pos[8:1]] <= {i_data_byte, r_pending};
            end
        end
        if (accept && is_packed) begin
            r_rd_scale0 <= r_scale_mem[idx0];
            r_rd_scale1 <= r_scale_mem[idx1];
            r_rd_zero0  <= r_zero_mem[idx0];
            r_rd_zero1  <= r_zero_mem[idx1];
        end
    end

    // Payload of the item waiting for the queue.
    always_ff @(posedge i_clk) begin
        if (accept && is_packed) begin
            r_f1_grid_row <= r_grid_row;
            r_f1_row_pair <= row0[4:1];
            r_f1_col      <= {r_tile_col, col8};
            r_f1_data     <= i_data_byte;
            r_f1_last     <= last_chunk && (r_byte_pos == int4dq_pkg::CHUNK_LAST);
        end
    end

    // Stream position counters and the low byte of a table entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_tile_col <= '0;
            r_grid_row <= '0;
            r_chunk    <= '0;
            r_pending  <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            if (accept && is_packed) begin
                r_f1_valid <= 1'b1;
            end else if (push) begin
                r_f1_valid <= 1'b0;
            end
            if (accept) begin
                if (!is_packed && !r_byte_pos[0]) begin
                    r_pending <= i_data_byte;
                end
                if (r_byte_pos == int4dq_pkg::CHUNK_LAST) begin
                    r_byte_pos <= '0;
                    if (last_chunk) begin
                        r_chunk    <= '0;
                        r_tile_col <= '0;
                        r_grid_row <= '0;
                    end else begin
                        r_chunk <= r_chunk + 17'd1;
                        if (({1'b0, r_tile_col} + 7'd1) >= cols_eff) begin
                            r_tile_col <= '0;
                            r_grid_row <= r_grid_row + 17'd1;
                        end else begin
                            r_tile_col <= r_tile_col + 6'd1;
                        end
                    end
                end else begin
                    r_byte_pos <= r_byte_pos + 13'd1;
                end
            end
        end
    end

    // Word handed to the queue.
    always_comb begin
        o_push_valid        = r_f1_valid;
        o_push_entry.grid_row = r_f1_grid_row;
        o_push_entry.row_pair = r_f1_row_pair;
        o_push_entry.col      = r_f1_col;
        o_push_entry.data     = r_f1_data;
        o_push_entry.scale0   = r_rd_scale0;
        o_push_entry.scale1   = r_rd_scale1;
        o_push_entry.zero0    = r_rd_zero0;
        o_push_entry.zero1    = r_rd_zero1;
        o_push_entry.last     = r_f1_last;
    end

endmodule

`default_nettype wire

>>> rtl/int4dq_queue.sv
// ----------------------------------------------------------------------------
// int4dq_queue: short work queue
// Holds packed bytes between the front end and the back end so that each
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module int4dq_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push_valid,
    output logic                 o_push_ready,
    input  int4dq_pkg::t_entry   i_push_entry,
    output logic                 o_pop_valid,
    input  wire                  i_pop,
    output int4dq_pkg::t_entry   o_pop_entry
);

    int4dq_pkg::t_entry             r_slot [int4dq_pkg::QUEUE_DEPTH];
    logic [int4dq_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [int4dq_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [int4dq_pkg::QUEUE_AW:0]   r_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != (int4dq_pkg::QUEUE_AW + 1)'(int4dq_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid & o_push_ready;
    assign pop          = i_pop & o_pop_valid;
    assign o_pop_entry  = r_slot[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/int4dq_back.sv
// ----------------------------------------------------------------------------
// int4dq_back: dequantisation arithmetic
// Splits each packed byte into two nibbles, computes v*scale+zp in binary32
// with round-to-nearest-even, one result word per cycle when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module int4dq_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_signed,
    input  wire                  i_pop_valid,
    output logic                 o_pop,
    input  int4dq_pkg::t_entry   i_entry,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [21:0]          o_out_row,
    output logic [13:0]          o_out_col,
    output logic [31:0]          o_weight_bits,
    output logic                 o_last_of_pair,
    output logic                 o_last_of_matrix
);

    // Non-finite or too large bf16 values read as +0.
    function automatic logic [15:0] bf16_clean(input logic [15:0] h);
        logic bad;
        bad = (h[14:7] == 8'hFF) || (h[14:0] > int4dq_pkg::BF16_LIMIT);
        return bad ? 16'h0000 : h;
    endfunction

    function automatic logic [3:0] lzc12(input logic [11:0] v);
        logic [3:0] n;
        n = 4'd12;
        for (int i = 0; i < 12; i++) begin
            if (v[i]) n = 4'(11 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc42(input logic [41:0] v);
        logic [5:0] n;
        n = 6'd42;
        for (int i = 0; i < 42; i++) begin
            if (v[i]) n = 6'(41 - i);
        end
        return n;
    endfunction

    logic en;
    logic r_half;

    // Stage 1: nibble decode and product.
    logic       r_v1;
    int4dq_pkg::t_tag r_t1;
    logic       r1_sp, r1_sz;
    logic [11:0] r1_mp;
    logic [7:0] r1_lp, r1_mz, r1_lz;

    // Stage 2: normalised operands.
    logic       r_v2;
    int4dq_pkg::t_tag r_t2;
    logic       r2_sa, r2_sb, r2_za, r2_zb;
    logic [11:0] r2_ma, r2_mb;
    logic signed [9:0] r2_ea, r2_eb;

    // Stage 3: operands ordered by magnitude.
    logic       r_v3;
    int4dq_pkg::t_tag r_t3;
    logic       r3_sx, r3_sub, r3_both_zero, r3_zsign;
    logic [11:0] r3_mx, r3_my;
    logic signed [9:0] r3_ex;
    logic [5:0] r3_dsh;

    // Stage 4: aligned sum.
    logic       r_v4;
    int4dq_pkg::t_tag r_t4;
    logic       r4_sx, r4_both_zero, r4_zsign;
    logic signed [9:0] r4_ex;
    logic [41:0] r4_sum;

    // Stage 5: normalised sum.
    logic       r_v5;
    int4dq_pkg::t_tag r_t5;
    logic       r5_sign, r5_zero;
    logic [41:0] r5_n;
    logic signed [9:0] r5_biased;

    // Stage 6: output register.
    logic       r_v6;
    int4dq_pkg::t_tag r_t6;
    logic [31:0] r6_bits;

    logic [3:0]  s1_q, s1_mag;
    logic        s1_neg;
    logic [15:0] s1_hs, s1_hz;
    logic [7:0]  s1_ms;
    int4dq_pkg::t_tag s1_tag;

    logic [3:0]  s2_lza, s2_lzb;
    logic [11:0] s2_mz12;

    logic signed [9:0] s3_ea, s3_eb;
    logic        s3_swap;
    logic signed [10:0] s3_d;

    logic [39:0] s4_bx, s4_by, s4_ys, s4_mask;
    logic        s4_st;

    logic [5:0]  s5_lz;

    logic [30:0] s6_pack;
    logic        s6_up;
    logic signed [9:0] s6_shv;
    logic [41:0] s6_t;

    assign en          = ~r_v6 | i_out_ready;
    assign o_pop       = en & i_pop_valid & r_half;
    assign o_out_valid = r_v6;
    assign o_out_row        = r_t6.row;
    assign o_out_col        = r_t6.col;
    assign o_last_of_pair   = r_t6.last_pair;
    assign o_last_of_matrix = r_t6.last_matrix;
    assign o_weight_bits    = r6_bits;

    // Nibble selection and operand decode.
    always_comb begin
        s1_q   = r_half ? i_entry.data[7:4] : i_entry.data[3:0];
        s1_neg = i_signed & s1_q[3];
        s1_mag = s1_neg ? 4'(5'd16 - {1'b0, s1_q}) : s1_q;
        s1_hs  = bf16_clean(r_half ? i_entry.scale1 : i_entry.scale0);
        s1_hz  = bf16_clean(r_half ? i_entry.zero1 : i_entry.zero0);
        s1_ms  = {s1_hs[14:7] != 8'd0, s1_hs[6:0]};
        s1_tag.row         = {i_entry.grid_row, i_entry.row_pair, r_half};
        s1_tag.col         = i_entry.col;
        s1_tag.last_pair   = r_half;
        s1_tag.last_matrix = r_half & i_entry.last;
    end

    // Normalisation of both operands.
    always_comb begin
        s2_mz12 = {r1_mz, 4'd0};
        s2_lza  = lzc12(r1_mp);
        s2_lzb  = lzc12(s2_mz12);
    end

    // Magnitude ordering.
    always_comb begin
        s3_ea   = r2_za ? -10'sd512 : r2_ea;
        s3_eb   = r2_zb ? -10'sd512 : r2_eb;
        s3_swap = (s3_eb > s3_ea) || ((s3_eb == s3_ea) && (r2_mb > r2_ma));
        s3_d    = s3_swap ? (11'(s3_eb) - 11'(s3_ea)) : (11'(s3_ea) - 11'(s3_eb));
    end

    // Alignment with sticky bit and the add or subtract.
    always_comb begin
        s4_bx   = {r3_mx, 28'd0};
        s4_by   = {r3_my, 28'd0};
        s4_ys   = s4_by >> r3_dsh;
        s4_mask = (40'd1 << r3_dsh) - 40'd1;
        s4_st   = |(s4_by & s4_mask);
    end

    assign s5_lz = lzc42(r4_sum);

    // Rounding and packing.
    always_comb begin
        s6_up   = r5_n[17] & ((|r5_n[16:0]) | r5_n[18]);
        s6_pack = {r5_biased[7:0], r5_n[40:18]} + {30'd0, s6_up};
        s6_shv  = 10'sd19 - r5_biased;
        s6_t    = r5_n >> s6_shv[5:0];
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1  <= s1_tag;
            r1_sp <= s1_neg ^ s1_hs[15];
            r1_mp <= {8'd0, s1_mag} * {4'd0, s1_ms};
            r1_lp <= (s1_hs[14:7] == 8'd0) ? 8'd0 : s1_hs[14:7] - 8'd1;
            r1_sz <= s1_hz[15];
            r1_mz <= {s1_hz[14:7] != 8'd0, s1_hz[6:0]};
            r1_lz <= (s1_hz[14:7] == 8'd0) ? 8'd0 : s1_hz[14:7] - 8'd1;

            r_t2  <= r_t1;
            r2_sa <= r1_sp;
            r2_sb <= r1_sz;
            r2_za <= r1_mp == 12'd0;
            r2_zb <= r1_mz == 8'd0;
            r2_ma <= r1_mp << s2_lza;
            r2_mb <= s2_mz12 << s2_lzb;
            r2_ea <= $signed({2'b00, r1_lp}) - 10'sd133 - $signed({6'd0, s2_lza});
            r2_eb <= $signed({2'b00, r1_lz}) - 10'sd137 - $signed({6'd0, s2_lzb});

            r_t3         <= r_t2;
            r3_sx        <= s3_swap ? r2_sb : r2_sa;
            r3_sub       <= r2_sa ^ r2_sb;
            r3_both_zero <= r2_za & r2_zb;
            r3_zsign     <= r2_sa & r2_sb;
            r3_mx        <= s3_swap ? r2_mb : r2_ma;
            r3_my        <= s3_swap ? r2_ma : r2_mb;
            r3_ex        <= s3_swap ? s3_eb : s3_ea;
            r3_dsh       <= (s3_d >= 11'sd40) ? 6'd40 : s3_d[5:0];

            r_t4         <= r_t3;
            r4_sx        <= r3_sx;
            r4_both_zero <= r3_both_zero;
            r4_zsign     <= r3_zsign;
            r4_ex        <= r3_ex;
            r4_sum       <= r3_sub ? ({1'b0, s4_bx, 1'b0} - {1'b0, s4_ys, s4_st})
                                   : ({1'b0, s4_bx, 1'b0} + {1'b0, s4_ys, s4_st});

            r_t5      <= r_t4;
            r5_zero   <= r4_sum == 42'd0;
            r5_sign   <= (r4_sum == 42'd0) ? (r4_both_zero & r4_zsign) : r4_sx;
            r5_n      <= r4_sum << s5_lz;
            r5_biased <= r4_ex + 10'sd139 - $signed({4'd0, s5_lz});

            r_t6 <= r_t5;
            if (r5_zero) begin
                r6_bits <= {r5_sign, 31'd0};
            end else if (r5_biased > 10'sd0) begin
                r6_bits <= {r5_sign, s6_pack};
            end else begin
                r6_bits <= {r5_sign, 8'd0, s6_t[22:0]};
            end
        end
    end

    // Stage valid bits and the nibble sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
        end else if (en) begin
            if (i_pop_valid) begin
                r_half <= ~r_half;
            end
            r_v1 <= i_pop_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

endmodule

`default_nettype wire

>>> rtl/int4_tile_dequantizer.sv
// ----------------------------------------------------------------------------
// int4_tile_dequantizer: int4 tile chunk dequantiser, top level
// Input channel: one chunk byte per word. The first 1024 bytes of each
// 5120-byte chunk load the bf16 scale and zero-point tables and give no
// result; each later packed byte gives two result words, low nibble first.
// Output channel: row, column, binary32 weight and the two end flags.
// Configuration channel: register index and data, always ready; the user must
// see it written only while the block is idle; the block does not enforce it.
// Throughput: one result word per cycle while the receiver is ready and the
// queue holds work; a packed byte gives two words and a table byte none.
// Path: a packed byte is registered in the front end with its table entries,
// then enters the work queue; its low-nibble word passes the six-stage
// binary32 multiply-add and then is valid at the output.
// Reset clears the stream counters, the queue and the pipeline; the tables
// hold nothing defined until loaded by a chunk.
// When the receiver stalls the back end holds, the four-entry queue fills
// and the input then stops taking words.
// ----------------------------------------------------------------------------
`default_nettype none

module int4_tile_dequantizer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [17:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [21:0] o_out_row,
    output logic [13:0] o_out_col,
    output logic [31:0] o_weight_bits,
    output logic        o_last_of_pair,
    output logic        o_last_of_matrix
);

    logic        r_group_major;
    logic        r_signed;
    logic [6:0]  r_tile_columns;
    logic [17:0] r_chunk_count;

    int4dq_pkg::t_front_cfg front_cfg;
    int4dq_pkg::t_entry     push_entry;
    int4dq_pkg::t_entry     pop_entry;
    logic push_valid, push_ready, pop_valid, pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_major  <= 1'b1;
            r_signed       <= 1'b0;
            r_tile_columns <= 7'd4;
            r_chunk_count  <= 18'd4;
        end else if (i_cfg_valid) begin
            case (int4dq_pkg::t_cfg_idx'(i_cfg_index))
                int4dq_pkg::CFG_GROUP_MAJOR: r_group_major  <= i_cfg_data[0];
                int4dq_pkg::CFG_SIGNED:      r_signed       <= i_cfg_data[0];
                int4dq_pkg::CFG_TILE_COLS:   r_tile_columns <= i_cfg_data[6:0];
                int4dq_pkg::CFG_CHUNKS:      r_chunk_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign front_cfg.group_major  = r_group_major;
    assign front_cfg.tile_columns = r_tile_columns;
    assign front_cfg.chunk_count  = r_chunk_count;

    int4dq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (front_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    int4dq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_entry  (pop_entry)
    );

    int4dq_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_signed         (r_signed),
        .i_pop_valid      (pop_valid),
        .o_pop            (pop),
        .i_entry          (pop_entry),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_weight_bits    (o_weight_bits),
        .o_last_of_pair   (o_last_of_pair),
        .o_last_of_matrix (o_last_of_matrix)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_int4_tile_dequantizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int4_tile_dequantizer: self-checking bench for the int4 tile dequantiser
// Streams the table part and the first packed bytes of a tile chunk through
// the byte channel under random idling on both sides, changing the format
// settings between bursts. A scoreboard object follows the chunk layout,
// fills its own scale and zero tables, and works out every weight exactly in
// binary32 with round-to-nearest-even. Results are checked in order.
// ----------------------------------------------------------------------------

module tb_int4_tile_dequantizer;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE_CYCLES = 16;

    // One expected output word.
    typedef struct {
        bit [21:0] row;
        bit [13:0] col;
        bit [31:0] weight;
        bit        last_pair;
        bit        last_matrix;
    } t_weight_word;

    // Follows the byte stream and holds the weights still to come.
    class t_weight_scoreboard;
        bit          group_major = 1'b1;
        bit          signed_q    = 1'b0;
        bit [6:0]    cols_reg    = 7'd4;
        bit [17:0]   chunks      = 18'd4;
        bit [15:0]   scales [256];
        bit [15:0]   zeros  [256];
        bit [7:0]    low_byte;
        int unsigned byte_pos;
        int unsigned col_idx;
        int unsigned row_idx;
        int unsigned chunk_idx;
        int unsigned words_checked;
        int unsigned failures;
        t_weight_word pending [$];

        function void set_reg(int4dq_pkg::t_cfg_idx idx, bit [17:0] val);
            case (idx)
                int4dq_pkg::CFG_GROUP_MAJOR: group_major = val[0];
                int4dq_pkg::CFG_SIGNED:      signed_q = val[0];
                int4dq_pkg::CFG_TILE_COLS:   cols_reg = val[6:0];
                int4dq_pkg::CFG_CHUNKS:      chunks = val;
                default: ;
            endcase
        endfunction

        // Splits a bf16 into sign and magnitude in units of 2^-133; unusable
        // values come back as positive zero.
        function void split_bf16(input bit [15:0] h, output bit s, output bit [159:0] m);
            int e;
            s = 1'b0;
            m = '0;
            if (h[14:7] != 8'hFF && h[14:0] <= int4dq_pkg::BF16_LIMIT) begin
                e = (h[14:7] == 0) ? 1 : int'(h[14:7]);
                m = 160'({h[14:7] != 0, h[6:0]}) << (e - 1);
                s = h[15];
            end
        endfunction

        // Rounds sign and magnitude (units of 2^-133) to a binary32 pattern.
        function bit [31:0] to_f32(bit s, bit [159:0] m);
            int p;
            int unit;
            int sh;
            bit [159:0] q;
            bit [159:0] rem;
            bit [159:0] half;
            if (m == 0) return {s, 31'd0};
            p = 0;
            for (int i = 0; i < 160; i++) if (m[i]) p = i;
            unit = p - 156;
            if (unit < -149) unit = -149;
            sh = unit + 133;
            if (sh <= 0) begin
                q = m << (-sh);
            end else begin
                q = m >> sh;
                rem = m & ((160'd1 << sh) - 1);
                half = 160'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 1;
            end
            if (q[24]) begin
                q = q >> 1;
                unit++;
            end
            if (!q[23]) return {s, 8'd0, q[22:0]};
            return {s, 8'(unit + 150), q[22:0]};
        endfunction

        function bit [31:0] weight_of(bit [3:0] q, int unsigned r, int unsigned col);
            int v;
            int unsigned grp;
            int unsigned si;
            bit ss, zs, ps, rs;
            bit [159:0] sm, zm, pm, rm;
            v = q;
            if (signed_q && v >= 8) v -= 16;
            grp = (col / 32) & 7;
            si = (group_major ? grp * 32 + r : r * 8 + grp) & 255;
            split_bf16(scales[si], ss, sm);
            split_bf16(zeros[si], zs, zm);
            ps = (v < 0) ^ ss;
            pm = sm * 160'(v < 0 ? -v : v);
            if (ps == zs) begin
                rm = pm + zm;
                rs = ps;
            end else if (pm > zm) begin
                rm = pm - zm;
                rs = ps;
            end else if (zm > pm) begin
                rm = zm - pm;
                rs = zs;
            end else begin
                rm = '0;
                rs = 1'b0;
            end
            return to_f32(rs, rm);
        endfunction

        // Notes one accepted stream byte and queues the weights it gives.
        function void note_byte(bit [7:0] b);
            int unsigned cols, nch, k, r0, col;
            bit last_chunk;
            t_weight_word w;
            cols = (cols_reg == 0) ? 1 : (cols_reg > 64 ? 64 : cols_reg);
            nch = (chunks == 0) ? 1 : (chunks > 131072 ? 131072 : chunks);
            last_chunk = (chunk_idx + 1 >= nch);
            if (byte_pos < 1024) begin
                if (!byte_pos[0]) begin
                    low_byte = b;
                end else if (byte_pos < 512) begin
                    scales[(byte_pos >> 1) & 255] = {b, low_byte};
                end else begin
                    zeros[((byte_pos - 512) >> 1) & 255] = {b, low_byte};
                end
            end else begin
                k = byte_pos - 1024;
                col = (k % 2048) / 8;
                r0 = ((k / 2048) & 1) * 16 + (k % 8) * 2;
                for (int j = 0; j < 2; j++) begin
                    w.row = 22'(row_idx * 32 + r0 + j);
                    w.col = 14'(col_idx * 256 + col);
                    w.weight = weight_of(j ? b[7:4] : b[3:0], r0 + j, col);
                    w.last_pair = (j == 1);
                    w.last_matrix = (j == 1) && last_chunk && (byte_pos == 5119);
                    pending.push_back(w);
                end
            end
            if (byte_pos == 5119) begin
                byte_pos = 0;
                if (last_chunk) begin
                    chunk_idx = 0;
                    col_idx = 0;
                    row_idx = 0;
                end else begin
                    chunk_idx = (chunk_idx + 1) & 32'h1FFFF;
                    if (col_idx + 1 >= cols) begin
                        col_idx = 0;
                        row_idx = (row_idx + 1) & 32'h1FFFF;
                    end else begin
                        col_idx++;
                    end
                end
            end else begin
                byte_pos++;
            end
        endfunction

        function void field_check(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
                failures++;
            end
        endfunction

        function void check_word(t_weight_word got);
            t_weight_word e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual row %0h col %0h w %0h",
                         $time, got.row, got.col, got.weight);
                failures++;
                return;
            end
            e = pending.pop_front();
            words_checked++;
            field_check("out_row", e.row, got.row);
            field_check("out_col", e.col, got.col);
            field_check("weight_bits", e.weight, got.weight);
            field_check("last_of_pair", e.last_pair, got.last_pair);
            field_check("last_of_matrix", e.last_matrix, got.last_matrix);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [17:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_out_ready = 1'b0;
    logic        o_cfg_ready, o_in_ready, o_out_valid;
    logic [21:0] o_out_row;
    logic [13:0] o_out_col;
    logic [31:0] o_weight_bits;
    logic        o_last_of_pair, o_last_of_matrix;

    t_weight_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned stall_left = 0;
    int unsigned corner_idx = 0;
    bit          quiet = 1'b0;
    bit [15:0]   table_entry;

    int4_tile_dequantizer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_data_byte(i_data_byte),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_row(o_out_row), .o_out_col(o_out_col), .o_weight_bits(o_weight_bits),
        .o_last_of_pair(o_last_of_pair), .o_last_of_matrix(o_last_of_matrix)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("[int4_tile_dequantizer] ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts except in the quiet tail.
    always @(posedge i_clk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 6) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_weight_word got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.row = o_out_row;
            got.col = o_out_col;
            got.weight = o_weight_bits;
            got.last_pair = o_last_of_pair;
            got.last_matrix = o_last_of_matrix;
            sb.check_word(got);
        end
    end

    // Mostly sane table values, with the awkward ones mixed in.
    function automatic bit [15:0] pick_bf16();
        bit [15:0] odd [10] = '{16'h7F80, 16'hFF80, 16'h7FC1, 16'h42C8, 16'hC2C8,
                                16'h42C9, 16'h0001, 16'h8000, 16'h0000, 16'h807F};
        case ($urandom_range(0, 7))
            0: return odd[$urandom_range(0, 9)];
            1: return 16'($urandom);
            default: return {1'($urandom), 8'($urandom_range(100, 133)), 7'($urandom)};
        endcase
    endfunction

    function automatic bit [7:0] next_byte();
        bit [7:0] corners [12] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h88, 8'h77,
                                   8'h80, 8'h08, 8'h7F, 8'hF7, 8'h55, 8'hAA};
        if (sb.byte_pos < 1024) begin
            if (!sb.byte_pos[0]) begin
                table_entry = pick_bf16();
                return table_entry[7:0];
            end
            return table_entry[15:8];
        end
        if (corner_idx < 12) return corners[corner_idx++];
        return 8'($urandom);
    endfunction

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(int4dq_pkg::t_cfg_idx idx, bit [17:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(bit gm, bit sg, bit [6:0] cols, bit [17:0] nch);
        write_reg(int4dq_pkg::CFG_GROUP_MAJOR, gm);
        write_reg(int4dq_pkg::CFG_SIGNED, sg);
        write_reg(int4dq_pkg::CFG_TILE_COLS, cols);
        write_reg(int4dq_pkg::CFG_CHUNKS, nch);
    endtask

    // Sends n stream words, idling now and then between them.
    task automatic stream_bytes(int unsigned n);
        bit [7:0] b;
        for (int unsigned i = 0; i < n; i++) begin
            b = next_byte();
            i_in_valid <= 1'b1;
            i_data_byte <= b;
            do @(posedge i_clk); while (!o_in_ready);
            sb.note_byte(b);
            bytes_sent++;
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default settings with the tables, then the format and geometry corners.
        configure(1'b1, 1'b0, 7'd4, 18'd4);
        stream_bytes(1024 + 180);
        wait_drained();
        configure(1'b0, 1'b1, 7'd64, 18'd0);
        stream_bytes(180);
        wait_drained();
        configure(1'b1, 1'b1, 7'd2, 18'h3FFFF);
        stream_bytes(180);
        wait_drained();
        configure(1'b0, 1'b0, 7'd0, 18'd3);
        stream_bytes(180);
        wait_drained();

        // Tail without idling on either side.
        quiet = 1'b1;
        configure(1'b1, 1'b0, 7'd127, 18'd131072);
        stream_bytes(160);
        wait_drained();

        $display("Sent %0d stream words over five settings; %0d weights checked.",
                 bytes_sent, sb.words_checked);
        if (sb.failures == 0) begin
            $display("[int4_tile_dequantizer] OK");
        end else begin
            $display("[int4_tile_dequantizer] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/int4dq_pkg.sv
rtl/int4dq_front.sv
rtl/int4dq_queue.sv
rtl/int4dq_back.sv
rtl/int4_tile_dequantizer.sv
tb/sv/tb_int4_tile_dequantizer.sv
